// ===== design/lroc_pkg.sv =====
// lroc_pkg: shared constants, payload and job types, cell helpers
// used by every module of the line raster overlap counter, no dependencies
package lroc_pkg;

  // grid geometry, GRID_SIZE is a power of two
  localparam int GRID_SIZE   = 1024;
  localparam int COUNT_WIDTH = 8;
  localparam int GRID_BITS   = $clog2(GRID_SIZE);
  localparam int ADDR_W      = 2 * GRID_BITS;
  localparam int DEPTH       = GRID_SIZE * GRID_SIZE;

  // field widths
  localparam int COORD_W   = 10;
  localparam int THR_W     = 8;
  localparam int OVL_W     = 21;
  localparam int CMP_W     = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
  localparam int CFG_IDX_W = 2;

  // job queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_WIDTH-1:0] CELL_MAX = '1;
  localparam logic [OVL_W-1:0]       OVL_MAX  = '1;

  // operation codes
  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_COUNT = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_SKIPPED = 2'd1;
  localparam logic [1:0] ST_SLOPE   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAGONAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  // configuration reset values
  localparam logic             RST_STRAIGHT  = 1'b1;
  localparam logic             RST_DIAGONAL  = 1'b1;
  localparam logic [THR_W-1:0] RST_THRESHOLD = 8'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OVL_W-1:0] overlap_count;
  } result_t;

  typedef enum logic [1:0] {
    JOB_REPORT,
    JOB_WALK,
    JOB_COUNT,
    JOB_CLEAR
  } job_kind_t;

  // one classified item as handed from front to back
  typedef struct packed {
    job_kind_t          kind;
    logic [1:0]         status;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               x_step;
    logic               y_step;
    logic               y_down;
    logic [COORD_W-1:0] len;
  } job_t;

  function automatic logic on_grid(input logic [COORD_W-1:0] coord);
    return 32'(coord) < 32'(GRID_SIZE);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
    return {GRID_BITS'(x), GRID_BITS'(y)};
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == CELL_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic meets_threshold(input logic [COUNT_WIDTH-1:0] c,
                                           input logic [THR_W-1:0] thr);
    return CMP_W'(c) >= CMP_W'(thr);
  endfunction

endpackage

// ===== design/lroc_front.sv =====
// lroc_front: accepts items, classifies drawable segments into walk jobs and all else into count, clear or report jobs
// depends on lroc_pkg
module lroc_front (
  input  logic           start,
  input  lroc_pkg::item_t item,
  input  logic           straight_enable,
  input  logic           diagonal_enable,
  input  logic           q_full,
  input  logic           init_busy,
  output logic           busy,
  output logic           push,
  output lroc_pkg::job_t job
);

  logic [lroc_pkg::COORD_W-1:0] xa, ya, xb, yb, ylo, yhi, dx, dy_abs;

  assign busy = init_busy | q_full;
  assign push = start & ~busy;

  always_comb begin
    // order end points by column
    if (item.start_x > item.end_x) begin
      xa = item.end_x;
      ya = item.end_y;
      xb = item.start_x;
      yb = item.start_y;
    end else begin
      xa = item.start_x;
      ya = item.start_y;
      xb = item.end_x;
      yb = item.end_y;
    end
    ylo    = (item.start_y > item.end_y) ? item.end_y : item.start_y;
    yhi    = (item.start_y > item.end_y) ? item.start_y : item.end_y;
    dx     = xb - xa;
    dy_abs = (yb > ya) ? yb - ya : ya - yb;

    job        = '0;
    job.kind   = lroc_pkg::JOB_REPORT;
    job.status = lroc_pkg::ST_DONE;

    unique case (item.operation)
      lroc_pkg::OP_DRAW: begin
        if (item.start_x == item.end_x) begin
          // vertical, a single point lands here too
          if (!straight_enable) begin
            job.status = lroc_pkg::ST_SKIPPED;
          end else begin
            job.kind   = lroc_pkg::JOB_WALK;
            job.x      = item.start_x;
            job.y      = ylo;
            job.y_step = 1'b1;
            job.len    = yhi - ylo;
          end
        end else if (ya == yb) begin
          if (!straight_enable) begin
            job.status = lroc_pkg::ST_SKIPPED;
          end else begin
            job.kind   = lroc_pkg::JOB_WALK;
            job.x      = xa;
            job.y      = ya;
            job.x_step = 1'b1;
            job.len    = dx;
          end
        end else if (dy_abs != dx) begin
          job.status = lroc_pkg::ST_SLOPE;
        end else if (!diagonal_enable) begin
          job.status = lroc_pkg::ST_SKIPPED;
        end else begin
          job.kind   = lroc_pkg::JOB_WALK;
          job.x      = xa;
          job.y      = ya;
          job.x_step = 1'b1;
          job.y_step = 1'b1;
          job.y_down = (yb < ya);
          job.len    = dx;
        end
      end
      lroc_pkg::OP_COUNT: job.kind = lroc_pkg::JOB_COUNT;
      lroc_pkg::OP_CLEAR: job.kind = lroc_pkg::JOB_CLEAR;
      default:            job.kind = lroc_pkg::JOB_REPORT;
    endcase
  end

endmodule

// ===== design/lroc_queue.sv =====
// lroc_queue: short job queue between front and back
// depends on lroc_pkg
module lroc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lroc_pkg::job_t push_job,
  input  logic           pop,
  output lroc_pkg::job_t head,
  output logic           full,
  output logic           empty
);

  lroc_pkg::job_t                slots [lroc_pkg::QUEUE_DEPTH];
  logic [lroc_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [lroc_pkg::QPTR_W:0]     fill;

  assign full  = (fill == (lroc_pkg::QPTR_W + 1)'(lroc_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == lroc_pkg::QPTR_W'(lroc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == lroc_pkg::QPTR_W'(lroc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== design/lroc_back.sv =====
// lroc_back: grid memory and the sequencer that walks, scans and clears it
// depends on lroc_pkg
module lroc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  lroc_pkg::job_t             head,
  input  logic                       empty,
  input  logic [lroc_pkg::THR_W-1:0] overlap_threshold,
  output logic                       pop,
  output logic                       init_busy,
  output logic                       done,
  output lroc_pkg::result_t          result
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_WALK_END,
    S_SCAN,
    S_SCAN_END,
    S_CLEAR
  } state_t;

  state_t                            state;
  logic [lroc_pkg::ADDR_W-1:0]       ptr;
  logic [lroc_pkg::COORD_W-1:0]      cur_x, cur_y, remain;
  logic                              x_step, y_step, y_down;
  logic                              pend_valid, pend_on;
  logic [lroc_pkg::ADDR_W-1:0]       pend_addr;
  logic [lroc_pkg::OVL_W-1:0]        acc, acc_next;

  logic [lroc_pkg::COUNT_WIDTH-1:0]  grid_mem [lroc_pkg::DEPTH];
  logic                              mem_we;
  logic [lroc_pkg::ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic [lroc_pkg::COUNT_WIDTH-1:0]  mem_wdata, mem_rdata;

  assign pop       = (state == S_IDLE) && !empty;
  assign init_busy = (state == S_INIT);

  // one read and one write a cycle; a walk never revisits a cell
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = '0;
    mem_raddr = ptr;
    case (state)
      S_INIT, S_CLEAR: mem_we = 1'b1;
      S_WALK, S_WALK_END: begin
        mem_we    = pend_valid && pend_on;
        mem_waddr = pend_addr;
        mem_wdata = lroc_pkg::sat_inc(mem_rdata);
        mem_raddr = lroc_pkg::cell_addr(cur_x, cur_y);
      end
      default: ;
    endcase
  end

  always_comb begin
    acc_next = acc;
    if (pend_valid && lroc_pkg::meets_threshold(mem_rdata, overlap_threshold) &&
        acc != lroc_pkg::OVL_MAX) begin
      acc_next = acc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    mem_rdata <= grid_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      ptr        <= '0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: begin
          ptr <= ptr + 1'b1;
          if (&ptr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!empty) begin
            pend_valid <= 1'b0;
            acc        <= '0;
            ptr        <= '0;
            case (head.kind)
              lroc_pkg::JOB_WALK: begin
                cur_x  <= head.x;
                cur_y  <= head.y;
                x_step <= head.x_step;
                y_step <= head.y_step;
                y_down <= head.y_down;
                remain <= head.len;
                state  <= S_WALK;
              end
              lroc_pkg::JOB_COUNT: state <= S_SCAN;
              lroc_pkg::JOB_CLEAR: state <= S_CLEAR;
              default: begin
                done                 <= 1'b1;
                result.status        <= head.status;
                result.overlap_count <= '0;
              end
            endcase
          end
        end
        S_WALK: begin
          pend_valid <= 1'b1;
          pend_addr  <= lroc_pkg::cell_addr(cur_x, cur_y);
          pend_on    <= lroc_pkg::on_grid(cur_x) && lroc_pkg::on_grid(cur_y);
          cur_x      <= cur_x + lroc_pkg::COORD_W'(x_step);
          cur_y      <= y_down ? cur_y - lroc_pkg::COORD_W'(y_step)
                               : cur_y + lroc_pkg::COORD_W'(y_step);
          remain     <= remain - 1'b1;
          if (remain == '0) begin
            state <= S_WALK_END;
          end
        end
        S_WALK_END: begin
          done                 <= 1'b1;
          result.status        <= lroc_pkg::ST_DONE;
          result.overlap_count <= '0;
          state                <= S_IDLE;
        end
        S_SCAN: begin
          pend_valid <= 1'b1;
          acc        <= acc_next;
          ptr        <= ptr + 1'b1;
          if (&ptr) begin
            state <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          done                 <= 1'b1;
          result.status        <= lroc_pkg::ST_DONE;
          result.overlap_count <= acc_next;
          state                <= S_IDLE;
        end
        S_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (&ptr) begin
            done                 <= 1'b1;
            result.status        <= lroc_pkg::ST_DONE;
            result.overlap_count <= '0;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/line_raster_overlap_counter.sv =====
// line_raster_overlap_counter: top level with configuration registers
// depends on lroc_pkg, lroc_front, lroc_queue, lroc_back
//
// usage
//   command channel: an item transfers at a clock edge with start high and
//   busy low. operation draw walks a vertical, horizontal or 45-degree
//   segment and bumps each covered cell (saturating), count scans the grid
//   for cells at or above overlap_threshold, clear zeroes the grid
//   result channel: every item gives one result on result, marked by done
//   for one cycle; the receiver cannot stall, results are never held
//   config channel: cfg_ready is always high, a transfer writes register
//   cfg_index (0 straight_enable, 1 diagonal_enable, 2 overlap_threshold)
//   timing: front classifies in the accept cycle and queues up to two jobs;
//   the back end does one grid memory read-modify-write per cycle while it
//   walks a draw, and count and clear sweep the grid one cell a cycle
//   busy is high while the queue is full
//   reset: registers return to their defaults and the grid is zeroed by a
//   clearing pass over all 2^20 cells, with busy held high throughout
module line_raster_overlap_counter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  lroc_pkg::item_t                item,
  output logic                           done,
  output lroc_pkg::result_t              result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lroc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lroc_pkg::THR_W-1:0]     cfg_data
);

  // configuration registers
  logic                       straight_enable;
  logic                       diagonal_enable;
  logic [lroc_pkg::THR_W-1:0] overlap_threshold;

  // front to queue
  logic           q_push;
  lroc_pkg::job_t q_job;

  // queue to back
  lroc_pkg::job_t q_head;
  logic           q_full, q_empty, q_pop;

  logic init_busy;

  // config writes must land only while idle; the user keeps to it, the block has no guard against live jobs
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      straight_enable   <= lroc_pkg::RST_STRAIGHT;
      diagonal_enable   <= lroc_pkg::RST_DIAGONAL;
      overlap_threshold <= lroc_pkg::RST_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lroc_pkg::CFG_STRAIGHT:  straight_enable   <= cfg_data[0];
        lroc_pkg::CFG_DIAGONAL:  diagonal_enable   <= cfg_data[0];
        lroc_pkg::CFG_THRESHOLD: overlap_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // classification of draw segments happens here, at the transfer
  lroc_front u_front (
    .start           (start),
    .item            (item),
    .straight_enable (straight_enable),
    .diagonal_enable (diagonal_enable),
    .q_full          (q_full),
    .init_busy       (init_busy),
    .busy            (busy),
    .push            (q_push),
    .job             (q_job)
  );

  lroc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // grid memory, walker, scanner and clearing sweep
  lroc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (q_head),
    .empty             (q_empty),
    .overlap_threshold (overlap_threshold),
    .pop               (q_pop),
    .init_busy         (init_busy),
    .done              (done),
    .result            (result)
  );

`ifndef SYNTH
  // no result may come out of the reset clearing pass
  a_no_done_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !done)
    else $error("result strobe during clearing pass");

  // back end pops only real jobs
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty job queue");

  // front pushes only when the queue has room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into full job queue");
`endif

endmodule

// ===== tb/tb_line_raster_overlap_counter.sv =====
// tb_line_raster_overlap_counter: self-checking bench for the line raster overlap counter
// drives draw, count, clear and unused items plus register writes, predicts every result
// on a private copy of the hit grid; depends on lroc_pkg and line_raster_overlap_counter
module tb_line_raster_overlap_counter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 4;   // idle negedges before a register write
  localparam int DRAIN_CYCLES  = 16;  // tail after the last result
  localparam int WIN           = 48;  // side of the busy window for random segments

  // what the sender queue holds: an item transfer or a register write
  typedef enum logic {CMD_ITEM, CMD_CFG} cmd_kind_t;

  typedef struct {
    cmd_kind_t                             kind;
    lroc_pkg::item_t                       payload;
    logic [lroc_pkg::CFG_IDX_W-1:0]        reg_index;
    logic [lroc_pkg::THR_W-1:0]            reg_value;
    int unsigned                           gap;
    bit                                    drain;
  } tb_cmd_t;

  // dut signals, the driven inputs all known from time zero
  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           start     = 1'b0;
  logic                           busy;
  lroc_pkg::item_t                item      = '0;
  logic                           done;
  lroc_pkg::result_t              result;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [lroc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lroc_pkg::THR_W-1:0]     cfg_data  = '0;

  // predictor state: private hit grid and register copies
  bit [lroc_pkg::COUNT_WIDTH-1:0] hit_grid [lroc_pkg::DEPTH];
  logic                           straight_on = lroc_pkg::RST_STRAIGHT;
  logic                           diagonal_on = lroc_pkg::RST_DIAGONAL;
  logic [lroc_pkg::THR_W-1:0]     overlap_thr = lroc_pkg::RST_THRESHOLD;

  tb_cmd_t           pending_cmds[$];     // filled up front, drained by the driver
  lroc_pkg::result_t pending_results[$];  // expected results, oldest first

  // driver / monitor handoff
  tb_cmd_t cur_cmd;
  bit      cmd_loaded  = 1'b0;
  bit      cmd_issued  = 1'b0;
  bit      item_moved  = 1'b0;
  bit      cfg_moved   = 1'b0;
  int      quiet_cycles = 0;

  // stimulus shaping
  bit      no_gaps        = 1'b0;
  bit      hold_for_drain = 1'b0;
  longint  stim_budget    = 0;
  longint  cycle_limit    = 64'h7fff_ffff_ffff;
  longint  cycles_run     = 0;

  // bookkeeping
  int fail_count   = 0;
  int n_items      = 0;
  int n_drawn      = 0;
  int n_skipped    = 0;
  int n_bad_slope  = 0;
  int n_counts     = 0;
  int n_clears     = 0;
  int n_cfg_writes = 0;

  line_raster_overlap_counter dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int span_of(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // bump n+1 cells from (x,y) stepping (sx,sy), counters stick at full scale
  function automatic void bump_run(input int x, input int y, input int sx, input int sy,
                                   input int n);
    int idx;
    for (int i = 0; i <= n; i++) begin
      if (x >= 0 && y >= 0 && x < lroc_pkg::GRID_SIZE && y < lroc_pkg::GRID_SIZE) begin
        idx = x * lroc_pkg::GRID_SIZE + y;
        if (hit_grid[idx] != lroc_pkg::CELL_MAX) hit_grid[idx] = hit_grid[idx] + 1'b1;
      end
      x += sx;
      y += sy;
    end
  endfunction

  // expected result of one accepted item, updates the private grid
  function automatic lroc_pkg::result_t predict_item(input lroc_pkg::item_t it);
    lroc_pkg::result_t res;
    int                x0, y0, x1, y1, t;
    int unsigned       tally;
    res.status        = lroc_pkg::ST_DONE;
    res.overlap_count = '0;
    x0 = it.start_x;
    y0 = it.start_y;
    x1 = it.end_x;
    y1 = it.end_y;
    tally = 0;
    case (it.operation)
      lroc_pkg::OP_DRAW: begin
        if (x0 == x1) begin
          // vertical, a single point lands here too
          if (!straight_on) res.status = lroc_pkg::ST_SKIPPED;
          else begin
            if (y0 > y1) begin
              t = y0; y0 = y1; y1 = t;
            end
            bump_run(x0, y0, 0, 1, y1 - y0);
          end
        end else begin
          // order by column so the walk always steps right
          if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
          end
          if (y0 == y1) begin
            if (!straight_on) res.status = lroc_pkg::ST_SKIPPED;
            else bump_run(x0, y0, 1, 0, x1 - x0);
          end else if (span_of(y0, y1) != x1 - x0) begin
            // slope check wins over the enables
            res.status = lroc_pkg::ST_SLOPE;
          end else if (!diagonal_on) begin
            res.status = lroc_pkg::ST_SKIPPED;
          end else begin
            bump_run(x0, y0, 1, (y1 > y0) ? 1 : -1, x1 - x0);
          end
        end
      end
      lroc_pkg::OP_COUNT: begin
        for (int i = 0; i < lroc_pkg::DEPTH; i++)
          if (hit_grid[i] >= overlap_thr && tally < lroc_pkg::OVL_MAX) tally++;
        res.overlap_count = tally[lroc_pkg::OVL_W-1:0];
      end
      lroc_pkg::OP_CLEAR: begin
        for (int i = 0; i < lroc_pkg::DEPTH; i++) hit_grid[i] = '0;
      end
      default: ;  // unused code changes nothing
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  task automatic push_item(input logic [1:0] op, input int sx, input int sy, input int ex,
                           input int ey);
    tb_cmd_t c;
    c.kind              = CMD_ITEM;
    c.payload.operation = op;
    c.payload.start_x   = lroc_pkg::COORD_W'(sx);
    c.payload.start_y   = lroc_pkg::COORD_W'(sy);
    c.payload.end_x     = lroc_pkg::COORD_W'(ex);
    c.payload.end_y     = lroc_pkg::COORD_W'(ey);
    c.reg_index         = '0;
    c.reg_value         = '0;
    c.gap               = pick_gap();
    c.drain             = hold_for_drain;
    hold_for_drain      = 1'b0;
    // worst case service time: sweeps take the whole grid, draws one cell a cycle
    if (op == lroc_pkg::OP_COUNT || op == lroc_pkg::OP_CLEAR)
      stim_budget += c.gap + lroc_pkg::DEPTH + 16;
    else stim_budget += c.gap + span_of(sx, ex) + span_of(sy, ey) + 16;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic push_cfg(input logic [lroc_pkg::CFG_IDX_W-1:0] idx,
                          input logic [lroc_pkg::THR_W-1:0] val);
    tb_cmd_t c;
    c.kind      = CMD_CFG;
    c.payload   = '0;
    c.reg_index = idx;
    c.reg_value = val;
    c.gap       = pick_gap();
    c.drain     = 1'b0;
    stim_budget += c.gap + 64;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // start point so that len steps of s stay inside [base, base+w)
  function automatic int pick_origin(input int base, input int w, input int s, input int len);
    if (s > 0) return base + $urandom_range(0, w - 1 - len);
    if (s < 0) return base + len + $urandom_range(0, w - 1 - len);
    return base + $urandom_range(0, w - 1);
  endfunction

  // one segment inside a w x w window at (bx,by), plus some noise and bad slopes
  task automatic push_random_segment(input int bx, input int by, input int w);
    int kind, len, sx, sy, x0, y0, x1, y1;
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      push_item(lroc_pkg::OP_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 1023));
      return;
    end
    if (kind < 10) begin
      x0 = bx + $urandom_range(0, w - 1);
      y0 = by + $urandom_range(0, w - 1);
      do begin
        x1 = bx + $urandom_range(0, w - 1);
        y1 = by + $urandom_range(0, w - 1);
      end while (x1 == x0 || y1 == y0 || span_of(x0, x1) == span_of(y0, y1));
      push_item(lroc_pkg::OP_DRAW, x0, y0, x1, y1);
      return;
    end
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, w - 1) : $urandom_range(0, 7);
    if (kind < 45) begin
      sx = 0; sy = 1;
    end else if (kind < 75) begin
      sx = 1; sy = 0;
    end else begin
      sx = 1; sy = $urandom_range(0, 1) ? 1 : -1;
    end
    // reverse half of them so end points arrive in either order
    if ($urandom_range(0, 1)) begin
      sx = -sx; sy = -sy;
    end
    x0 = pick_origin(bx, w, sx, len);
    y0 = pick_origin(by, w, sy, len);
    x1 = x0 + sx * len;
    y1 = y0 + sy * len;
    push_item(lroc_pkg::OP_DRAW, x0, y0, x1, y1);
  endtask

  // short segments crossing one cell so its counter runs into saturation
  task automatic push_hot_segment(input int hx, input int hy);
    int r, len, off, x0, y0, x1, y1;
    len = $urandom_range(0, 7);
    off = $urandom_range(0, len);
    r   = $urandom_range(0, 99);
    if (r < 46) begin
      x0 = hx; x1 = hx; y0 = hy - off; y1 = y0 + len;
    end else if (r < 90) begin
      y0 = hy; y1 = hy; x0 = hx - off; x1 = x0 + len;
    end else if (r < 96) begin
      x0 = hx - off; y0 = hy - off; x1 = x0 + len; y1 = y0 + len;
    end else begin
      push_random_segment(hx - 20, hy - 20, WIN);
      return;
    end
    if ($urandom_range(0, 1)) push_item(lroc_pkg::OP_DRAW, x1, y1, x0, y0);
    else push_item(lroc_pkg::OP_DRAW, x0, y0, x1, y1);
  endtask

  // random part of a phase: mostly a busy window, a few segments across the grid
  task automatic push_random_phase(input int n_segs);
    int bx, by;
    bx = $urandom_range(0, lroc_pkg::GRID_SIZE - WIN);
    by = $urandom_range(0, lroc_pkg::GRID_SIZE - WIN);
    for (int i = 0; i < n_segs; i++) begin
      if ($urandom_range(0, 49) == 0) push_random_segment(0, 0, lroc_pkg::GRID_SIZE);
      else push_random_segment(bx, by, WIN);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: changes inputs on the falling edge, one nonblocking write per signal
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive
    logic nxt_start, nxt_cfg_valid;
    nxt_start     = start;
    nxt_cfg_valid = cfg_valid;
    if (pending_results.size() == 0) quiet_cycles++;
    else quiet_cycles = 0;
    if (rst) begin
      nxt_start     = 1'b0;
      nxt_cfg_valid = 1'b0;
    end else begin
      // the monitor saw the transfer on the last rising edge
      if (item_moved || cfg_moved) begin
        if (item_moved) nxt_start = 1'b0;
        if (cfg_moved) nxt_cfg_valid = 1'b0;
        item_moved = 1'b0;
        cfg_moved  = 1'b0;
        cmd_loaded = 1'b0;
        cmd_issued = 1'b0;
      end
      if (!cmd_loaded && pending_cmds.size() != 0) begin
        cur_cmd    = pending_cmds.pop_front();
        cmd_loaded = 1'b1;
      end
      if (cmd_loaded && !cmd_issued) begin
        if (cur_cmd.gap != 0) begin
          cur_cmd.gap--;
        end else if (cur_cmd.kind == CMD_CFG) begin
          // registers only change once the block has gone quiet
          if (quiet_cycles >= SETTLE_CYCLES) begin
            cfg_index     <= cur_cmd.reg_index;
            cfg_data      <= cur_cmd.reg_value;
            nxt_cfg_valid = 1'b1;
            cmd_issued    = 1'b1;
          end
        end else if (!cur_cmd.drain || pending_results.size() == 0) begin
          item       <= cur_cmd.payload;
          nxt_start  = 1'b1;
          cmd_issued = 1'b1;
        end
      end
    end
    start     <= nxt_start;
    cfg_valid <= nxt_cfg_valid;
  end

  // ---------------------------------------------------------------------------
  // monitor: samples on the rising edge, checks results, records transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    lroc_pkg::result_t want, got;
    cycles_run++;
    if (cycles_run > cycle_limit) begin
      $display("TEST FAILED");
      $finish;
    end else if (!rst) begin
      // results first, so a transfer on this edge never meets its own result
      if (done) begin
        got = result;
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d, overlap_count %0d",
                 got.status, got.overlap_count);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
          end
          if (got.overlap_count !== want.overlap_count) begin
            $error("overlap_count mismatch: expected %0d, actual %0d",
                   want.overlap_count, got.overlap_count);
            fail_count++;
          end
        end
      end
      // item transfer: predict in acceptance order
      if (start && !busy) begin
        want = predict_item(item);
        pending_results.insert(pending_results.size(), want);
        item_moved = 1'b1;
        n_items++;
        case (item.operation)
          lroc_pkg::OP_DRAW: begin
            if (want.status == lroc_pkg::ST_DONE) n_drawn++;
            else if (want.status == lroc_pkg::ST_SKIPPED) n_skipped++;
            else n_bad_slope++;
          end
          lroc_pkg::OP_COUNT: n_counts++;
          lroc_pkg::OP_CLEAR: n_clears++;
          default: ;
        endcase
      end
      // register write transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lroc_pkg::CFG_STRAIGHT:  straight_on = cfg_data[0];
          lroc_pkg::CFG_DIAGONAL:  diagonal_on = cfg_data[0];
          lroc_pkg::CFG_THRESHOLD: overlap_thr = cfg_data;
          default: ;
        endcase
        cfg_moved = 1'b1;
        n_cfg_writes++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : run
    int hx, hy;

    // phase 1, reset defaults: extremes, both orders, every class and operation
    push_item(lroc_pkg::OP_DRAW, 0, 0, 0, 0);               // single point at the origin
    push_item(lroc_pkg::OP_DRAW, 1023, 1023, 1023, 1023);   // single point, far corner
    push_item(lroc_pkg::OP_DRAW, 0, 1023, 0, 0);            // full column, reversed
    push_item(lroc_pkg::OP_DRAW, 1023, 1023, 0, 1023);      // full row, reversed
    push_item(lroc_pkg::OP_DRAW, 0, 0, 1023, 0);            // full row
    push_item(lroc_pkg::OP_DRAW, 0, 0, 1023, 1023);         // rising main diagonal
    push_item(lroc_pkg::OP_DRAW, 0, 1023, 1023, 0);         // falling main diagonal
    push_item(lroc_pkg::OP_DRAW, 1023, 0, 0, 1023);         // same cells, other order
    push_item(lroc_pkg::OP_DRAW, 10, 20, 5, 15);            // short rising, reversed
    push_item(lroc_pkg::OP_DRAW, 0, 0, 1, 2);               // steep slope
    push_item(lroc_pkg::OP_DRAW, 1023, 1023, 0, 1);         // nearly diagonal
    push_item(lroc_pkg::OP_DRAW, 5, 5, 7, 4);               // shallow falling slope
    push_item(lroc_pkg::OP_NONE, 1023, 1023, 1023, 1023);   // unused code, fields all ones
    push_item(lroc_pkg::OP_NONE, 0, 0, 0, 0);
    push_item(lroc_pkg::OP_DRAW, 512, 100, 512, 110);
    push_item(lroc_pkg::OP_DRAW, 505, 105, 520, 105);       // crosses the column above
    push_item(lroc_pkg::OP_COUNT, 0, 0, 0, 0);
    push_item(lroc_pkg::OP_CLEAR, 1023, 0, 1023, 0);
    // threshold zero: every cell counts, so the count covers the whole grid
    push_cfg(lroc_pkg::CFG_THRESHOLD, 8'd0);
    push_item(lroc_pkg::OP_COUNT, 1023, 1023, 0, 0);

    // phase 2: straight off, diagonals on, lowest nonzero threshold
    push_cfg(lroc_pkg::CFG_STRAIGHT, {7'($urandom), 1'b0});
    push_cfg(lroc_pkg::CFG_DIAGONAL, {7'($urandom), 1'b1});
    push_cfg(lroc_pkg::CFG_THRESHOLD, 8'd1);
    push_random_phase(300);
    push_item(lroc_pkg::OP_COUNT, 0, 0, 0, 0);

    // phase 3: diagonals off, top threshold, hammer one cell into saturation
    push_cfg(lroc_pkg::CFG_STRAIGHT, {7'($urandom), 1'b1});
    push_cfg(lroc_pkg::CFG_DIAGONAL, {7'($urandom), 1'b0});
    push_cfg(lroc_pkg::CFG_THRESHOLD, 8'd255);
    hx = $urandom_range(32, 990);
    hy = $urandom_range(32, 990);
    no_gaps = 1'b1;  // a stretch of back to back transfers
    for (int i = 0; i < 360; i++) begin
      if (i == 120) no_gaps = 1'b0;
      push_hot_segment(hx, hy);
    end
    push_item(lroc_pkg::OP_COUNT, 0, 0, 0, 0);

    // phase 4: everything on, mid threshold, one full drain halfway through
    push_cfg(lroc_pkg::CFG_DIAGONAL, {7'($urandom), 1'b1});
    push_cfg(lroc_pkg::CFG_THRESHOLD, 8'd3);
    for (int i = 0; i < 470; i += 235) begin
      if (i != 0) hold_for_drain = 1'b1;
      push_random_phase(235);
    end
    push_item(lroc_pkg::OP_COUNT, 0, 0, 0, 0);

    // generous bound: worst case service time, the clearing pass, then margin
    cycle_limit = 3 * stim_budget + 3 * lroc_pkg::DEPTH + 100000;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || cmd_loaded || pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d segments drawn, %0d skipped, %0d bad slopes",
             n_items, n_drawn, n_skipped, n_bad_slope);
    $display("  %0d overlap counts, %0d grid clears, %0d register writes",
             n_counts, n_clears, n_cfg_writes);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lroc_pkg.sv
design/lroc_front.sv
design/lroc_queue.sv
design/lroc_back.sv
design/line_raster_overlap_counter.sv
tb/tb_line_raster_overlap_counter.sv
